// ----- src/hll_pkg.sv -----
package hll_pkg;

   localparam int CMD_W         = 2;
   localparam int HASH_W        = 64;
   localparam int REG_INDEX_W   = 12;
   localparam int RANK_W        = 6;
   localparam int ZERO_COUNT_W  = 13;
   localparam int HARMONIC_W    = 60;
   localparam int TOP_BIT       = 63;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_ADD   = 2'd0;
   localparam cmd_type CMD_MERGE = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   typedef struct packed {
      cmd_type                 cmd;
      logic [HASH_W-1:0]       hash;
      logic [REG_INDEX_W-1:0]  reg_index;
      logic [RANK_W-1:0]       merge_value;
   } req_payload_type;

   typedef struct packed {
      logic [RANK_W-1:0]       reg_value;
      logic [ZERO_COUNT_W-1:0] zero_registers;
      logic [HARMONIC_W-1:0]   harmonic_sum;
   } rsp_payload_type;

endpackage

// ----- src/hll_channels.sv -----
interface hll_req_if import hll_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hll_rsp_if import hll_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/hyperloglog_register_update.sv -----
// HyperLogLog register sketch with 2^PRECISION rank registers. Each transfer on req adds a
// hash, merges one register of another sketch or reads a register, and yields one transfer
// on rsp with the touched register, the count of zero registers and the harmonic sum in
// fixed point with FRACTION_BITS fraction bits. One item is taken per cycle while
// req.ready is high; the memory clear and a stalled rsp hold it low. The register memory
// is read as the item is taken and written back as it leaves stage s1, with a bypass
// for back-to-back items at the same index; from stage s1 an item moves to the result
// register when that register is free. After reset the memory is cleared entry by entry.
module hyperloglog_register_update
   import hll_pkg::*;
#(
   parameter int PRECISION     = 12,
   parameter int FRACTION_BITS = 47
) (
   input  logic      clock,
   input  logic      reset,
   hll_req_if.sink   req,
   hll_rsp_if.source rsp
);

   localparam int CNT_W = PRECISION + 1;
   localparam int SUM_W = PRECISION + FRACTION_BITS + 1;
   localparam int IDX_W = (PRECISION > REG_INDEX_W) ? PRECISION : REG_INDEX_W;
   localparam int ZOUT_W = (CNT_W > ZERO_COUNT_W) ? CNT_W : ZERO_COUNT_W;
   localparam int SOUT_W = (SUM_W > HARMONIC_W) ? SUM_W : HARMONIC_W;
   localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(HASH_W - PRECISION);
   localparam logic [RANK_W:0] FRAC_SHIFT = (RANK_W + 1)'(FRACTION_BITS);

   function automatic logic [SUM_W-1:0] term_of(input logic [RANK_W-1:0] v);
      logic [RANK_W:0] amount;
      amount = FRAC_SHIFT - {1'b0, v};
      if ({1'b0, v} > FRAC_SHIFT) begin
         return '0;
      end
      return SUM_W'(1) << amount;
   endfunction

   logic                  accept;
   logic                  s1_adv;
   logic                  busy;
   logic [IDX_W-1:0]      wide_index;
   logic [PRECISION-1:0]  in_idx;

   logic                  s1_vld_ff;
   cmd_type               s1_cmd_ff;
   logic [HASH_W-1:0]     s1_hash_ff;
   logic [PRECISION-1:0]  s1_idx_ff;
   logic [RANK_W-1:0]     s1_mv_ff;

   logic                  fwd_vld_ff;
   logic [PRECISION-1:0]  fwd_idx_ff;
   logic [RANK_W-1:0]     fwd_val_ff;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;

   logic                  out_vld_ff;
   logic [RANK_W-1:0]     out_val_ff;
   logic [CNT_W-1:0]      out_count_ff;
   logic [SUM_W-1:0]      out_sum_ff;

   logic [RANK_W-1:0]     rank;
   logic [RANK_W-1:0]     rd_data;
   logic [RANK_W-1:0]     old_val;
   logic [RANK_W-1:0]     new_val;
   logic [RANK_W-1:0]     final_val;
   logic                  is_update;
   logic                  raise;
   logic                  wr_en;
   logic [ZOUT_W-1:0]     zero_wide;
   logic [SOUT_W-1:0]     sum_wide;

   assign s1_adv     = s1_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready  = !busy && (!s1_vld_ff || s1_adv);
   assign accept     = req.valid && req.ready;

   assign wide_index = IDX_W'(req.payload.reg_index);
   assign in_idx     = (req.payload.cmd == CMD_ADD) ? req.payload.hash[PRECISION-1:0]
                                                    : wide_index[PRECISION-1:0];

   hll_rank_enc #(
      .PRECISION (PRECISION)
   ) u_rank (
      .hash (s1_hash_ff),
      .rank (rank)
   );

   hll_store #(
      .PRECISION (PRECISION)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (in_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (final_val),
      .busy    (busy)
   );

   // A write at the edge that read the memory for this item is not seen by that read.
   assign old_val = (fwd_vld_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_val_ff : rd_data;

   always_comb begin
      case (s1_cmd_ff)
         CMD_ADD: begin
            is_update = 1'b1;
            new_val   = rank;
         end
         CMD_MERGE: begin
            is_update = 1'b1;
            new_val   = (s1_mv_ff > MAX_RANK) ? MAX_RANK : s1_mv_ff;
         end
         default: begin
            is_update = 1'b0;
            new_val   = old_val;
         end
      endcase
   end

   assign raise     = is_update && (new_val > old_val);
   assign final_val = raise ? new_val : old_val;
   assign wr_en     = s1_adv && raise;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (raise) begin
         if (old_val == '0) begin
            count_in = count_ff - 1'b1;
         end
         sum_in = sum_ff - term_of(old_val) + term_of(new_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         count_ff   <= CNT_W'(1) << PRECISION;
         sum_ff     <= SUM_W'(1) << (PRECISION + FRACTION_BITS);
      end else begin
         if (accept) begin
            s1_vld_ff  <= 1'b1;
            fwd_vld_ff <= wr_en;
         end else if (s1_adv) begin
            s1_vld_ff  <= 1'b0;
         end
         if (s1_adv) begin
            out_vld_ff <= 1'b1;
            count_ff   <= count_in;
            sum_ff     <= sum_in;
         end else if (rsp.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req.payload.cmd;
         s1_hash_ff <= req.payload.hash;
         s1_idx_ff  <= in_idx;
         s1_mv_ff   <= req.payload.merge_value;
         fwd_idx_ff <= s1_idx_ff;
         fwd_val_ff <= final_val;
      end
      if (s1_adv) begin
         out_val_ff   <= final_val;
         out_count_ff <= count_in;
         out_sum_ff   <= sum_in;
      end
   end

   assign zero_wide = ZOUT_W'(out_count_ff);
   assign sum_wide  = SOUT_W'(out_sum_ff);

   assign rsp.valid                  = out_vld_ff;
   assign rsp.payload.reg_value      = out_val_ff;
   assign rsp.payload.zero_registers = zero_wide[ZERO_COUNT_W-1:0];
   assign rsp.payload.harmonic_sum   = sum_wide[HARMONIC_W-1:0];

endmodule

// ----- src/hll_rank_enc.sv -----
module hll_rank_enc
   import hll_pkg::*;
#(
   parameter int PRECISION = 12
) (
   input  logic [HASH_W-1:0] hash,
   output logic [RANK_W-1:0] rank
);

   localparam int SHIFTED_W = HASH_W - PRECISION;

   logic [HASH_W-1:0]    forced;
   logic [SHIFTED_W-1:0] shifted;

   assign forced  = hash | (HASH_W'(1) << TOP_BIT);
   assign shifted = forced[HASH_W-1:PRECISION];

   // The lowest set bit wins because it is visited last.
   always_comb begin
      rank = RANK_W'(SHIFTED_W);
      for (int i = SHIFTED_W - 1; i >= 0; i--) begin
         if (shifted[i]) begin
            rank = RANK_W'(i + 1);
         end
      end
   end

endmodule

// ----- src/hll_store.sv -----
module hll_store
   import hll_pkg::*;
#(
   parameter int PRECISION = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [PRECISION-1:0] rd_addr,
   output logic [RANK_W-1:0]    rd_data,
   input  logic                 wr_en,
   input  logic [PRECISION-1:0] wr_addr,
   input  logic [RANK_W-1:0]    wr_data,
   output logic                 busy
);

   localparam int DEPTH = 2 ** PRECISION;

   logic [RANK_W-1:0]    mem [DEPTH];
   logic [RANK_W-1:0]    rd_data_ff;
   logic                 clr_active_ff;
   logic                 clr_active_in;
   logic [PRECISION-1:0] clr_idx_ff;
   logic [PRECISION-1:0] clr_idx_in;

   // After reset every entry is cleared in turn, one per cycle.
   always_comb begin
      clr_idx_in    = clr_idx_ff;
      clr_active_in = clr_active_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (&clr_idx_ff) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

endmodule

// ----- verif/testbench.sv -----
module testbench;
   import hll_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRECISION     = 12;
   localparam int FRACTION_BITS = 47;
   localparam int REG_COUNT     = 1 << PRECISION;
   localparam int MAX_RANK      = 64 - PRECISION;
   localparam int RANDOM_ITEMS  = 1530;
   localparam int PAUSE_AT      = 700;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_LIMIT    = 20000;
   localparam int REPORT_LINES  = 50;

   localparam cmd_type CMD_UNUSED = 2'd3;

   localparam logic [HARMONIC_W-1:0] FULL_SUM = 60'(REG_COUNT) << FRACTION_BITS;
   localparam logic [HARMONIC_W-1:0] ONE_TERM = 60'd1 << FRACTION_BITS;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type result;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            send_valid   = 1'b0;
   req_payload_type send_payload = '0;
   logic            sink_ready   = 1'b0;

   hll_req_if req_ch ();
   hll_rsp_if rsp_ch ();

   assign req_ch.valid   = send_valid;
   assign req_ch.payload = send_payload;
   assign rsp_ch.ready   = sink_ready;

   hyperloglog_register_update #(
      .PRECISION     (PRECISION),
      .FRACTION_BITS (FRACTION_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [RANK_W-1:0]       sketch_ranks [REG_COUNT];
   logic [ZERO_COUNT_W-1:0] sketch_zeros = ZERO_COUNT_W'(REG_COUNT);
   logic [HARMONIC_W-1:0]   sketch_sum   = FULL_SUM;

   rsp_payload_type  pending_results [$];
   stimulus_row_type directed_rows [$];

   int error_count     = 0;
   int results_checked = 0;
   int cmd_seen [4]    = '{0, 0, 0, 0};
   int idle_cycles     = 0;
   int unsigned hot_base = 0;

   function automatic logic [RANK_W-1:0] hash_rank(logic [HASH_W-1:0] hash);
      logic [HASH_W-1:0] shifted;
      int                rank;
      shifted = (hash | (64'd1 << TOP_BIT)) >> PRECISION;
      rank    = 1;
      while (shifted[0] == 1'b0) begin
         rank++;
         shifted = shifted >> 1;
      end
      return rank[RANK_W-1:0];
   endfunction

   function automatic logic [HARMONIC_W-1:0] harmonic_term(logic [RANK_W-1:0] value);
      if (value > FRACTION_BITS) begin
         return '0;
      end
      return 60'd1 << (FRACTION_BITS - value);
   endfunction

   function automatic void raise_register(logic [REG_INDEX_W-1:0] index,
                                          logic [RANK_W-1:0] value);
      logic [RANK_W-1:0] old_value;
      old_value = sketch_ranks[index];
      if (value > old_value) begin
         if (old_value == '0) begin
            sketch_zeros = sketch_zeros - 1'b1;
         end
         sketch_sum = sketch_sum - harmonic_term(old_value) + harmonic_term(value);
         sketch_ranks[index] = value;
      end
   endfunction

   function automatic rsp_payload_type update_sketch(req_payload_type item);
      rsp_payload_type        result;
      logic [REG_INDEX_W-1:0] index;
      logic [RANK_W-1:0]      value;
      index = item.reg_index;
      if (item.cmd == CMD_ADD) begin
         index = item.hash[REG_INDEX_W-1:0];
         raise_register(index, hash_rank(item.hash));
      end else if (item.cmd == CMD_MERGE) begin
         value = (item.merge_value > MAX_RANK) ? RANK_W'(MAX_RANK) : item.merge_value;
         raise_register(index, value);
      end
      result.reg_value      = sketch_ranks[index];
      result.zero_registers = sketch_zeros;
      result.harmonic_sum   = sketch_sum;
      return result;
   endfunction

   function automatic void add_row(cmd_type cmd, logic [HASH_W-1:0] hash,
                                   logic [REG_INDEX_W-1:0] index, logic [RANK_W-1:0] value,
                                   bit typed = 1'b0,
                                   logic [RANK_W-1:0] want_value = '0,
                                   logic [ZERO_COUNT_W-1:0] want_zeros = '0,
                                   logic [HARMONIC_W-1:0] want_sum = '0);
      stimulus_row_type row;
      row.item.cmd                = cmd;
      row.item.hash               = hash;
      row.item.reg_index          = index;
      row.item.merge_value        = value;
      row.typed                   = typed;
      row.result.reg_value        = want_value;
      row.result.zero_registers   = want_zeros;
      row.result.harmonic_sum     = want_sum;
      directed_rows.push_back(row);
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type        item;
      int unsigned            pick;
      int unsigned            keep;
      logic [REG_INDEX_W-1:0] index;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         item.cmd = CMD_ADD;
      end else if (pick < 80) begin
         item.cmd = CMD_MERGE;
      end else if (pick < 95) begin
         item.cmd = CMD_READ;
      end else begin
         item.cmd = CMD_UNUSED;
      end
      if ($urandom_range(0, 2) == 0) begin
         index = REG_INDEX_W'(hot_base + $urandom_range(0, 3));
      end else begin
         index = REG_INDEX_W'($urandom_range(0, REG_COUNT - 1));
      end
      item.hash = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1) begin
         keep      = $urandom_range(0, MAX_RANK);
         item.hash = item.hash & ~(((64'd1 << keep) - 64'd1) << PRECISION);
      end
      item.merge_value = RANK_W'($urandom_range(0, 63));
      if (item.cmd == CMD_ADD) begin
         item.hash[REG_INDEX_W-1:0] = index;
         item.reg_index = REG_INDEX_W'($urandom_range(0, REG_COUNT - 1));
      end else begin
         item.reg_index = index;
      end
      return item;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < REPORT_LINES) begin
         $display("testbench: mismatch on %s: got %0d, expected %0d", what, got, want);
      end
      error_count++;
   endtask

   task automatic send_item(req_payload_type item, bit typed, rsp_payload_type typed_result);
      rsp_payload_type predicted;
      send_valid   <= 1'b1;
      send_payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      predicted = update_sketch(item);
      pending_results.push_back(typed ? typed_result : predicted);
      cmd_seen[item.cmd]++;
   endtask

   logic [15:0] stall_pattern = 16'hFFFF;
   int unsigned stall_phase   = 0;
   int unsigned stall_cycles  = 0;

   always @(posedge clock) begin
      if (stall_cycles % 256 == 0) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
      end
      sink_ready   <= stall_pattern[stall_phase];
      stall_phase  <= (stall_phase + 1) % 16;
      stall_cycles <= stall_cycles + 1;
   end

   rsp_payload_type oldest_result;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_ch.payload.reg_value, 0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_ch.payload.reg_value !== oldest_result.reg_value) begin
               report_mismatch("reg_value", rsp_ch.payload.reg_value,
                               oldest_result.reg_value);
            end
            if (rsp_ch.payload.zero_registers !== oldest_result.zero_registers) begin
               report_mismatch("zero_registers", rsp_ch.payload.zero_registers,
                               oldest_result.zero_registers);
            end
            if (rsp_ch.payload.harmonic_sum !== oldest_result.harmonic_sum) begin
               report_mismatch("harmonic_sum", rsp_ch.payload.harmonic_sum,
                               oldest_result.harmonic_sum);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: no transfer for %0d cycles", idle_cycles);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned burst_left;
      int unsigned gap;
      req_payload_type item;
      rsp_payload_type no_result;

      burst_left = 0;
      no_result  = '0;
      foreach (sketch_ranks[i]) begin
         sketch_ranks[i] = '0;
      end

      add_row(CMD_READ,   64'd0, 12'd0, 6'd0, 1'b1, 6'd0, 13'd4096, FULL_SUM);
      add_row(CMD_ADD,    64'd0, 12'd0, 6'd0, 1'b1, 6'd52, 13'd4095, FULL_SUM - ONE_TERM);
      add_row(CMD_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 6'd0, 1'b1, 6'd1, 13'd4094,
              FULL_SUM - 2 * ONE_TERM + (ONE_TERM >> 1));
      add_row(CMD_UNUSED, 64'd0, 12'hFFF, 6'd63, 1'b1, 6'd1, 13'd4094,
              FULL_SUM - 2 * ONE_TERM + (ONE_TERM >> 1));
      add_row(CMD_MERGE,  64'd0, 12'd0, 6'd63, 1'b1, 6'd52, 13'd4094,
              FULL_SUM - 2 * ONE_TERM + (ONE_TERM >> 1));
      add_row(CMD_MERGE,  64'd0, 12'd5, 6'd63);
      add_row(CMD_MERGE,  64'd0, 12'd6, 6'd0);
      add_row(CMD_MERGE,  64'd0, 12'd7, 6'd47);
      add_row(CMD_MERGE,  64'd0, 12'd8, 6'd48);
      add_row(CMD_MERGE,  64'd0, 12'd9, 6'd53);
      add_row(CMD_MERGE,  64'd0, 12'd10, 6'd52);
      add_row(CMD_ADD,    (64'd1 << 12) | 64'd20, 12'hABC, 6'd0);
      add_row(CMD_ADD,    (64'd1 << 62) | 64'd21, 12'd0, 6'd0);
      add_row(CMD_ADD,    (64'd1 << 59) | 64'd22, 12'd0, 6'd0);
      add_row(CMD_ADD,    (64'd1 << 58) | 64'd23, 12'd0, 6'd0);
      add_row(CMD_MERGE,  64'd0, 12'd7, 6'd3);
      add_row(CMD_ADD,    (64'd1 << 12) | 64'd7, 12'd0, 6'd0);
      add_row(CMD_MERGE,  64'd0, 12'd30, 6'd2);
      add_row(CMD_ADD,    (64'd1 << 16) | 64'd30, 12'd0, 6'd0);
      add_row(CMD_MERGE,  64'd0, 12'd30, 6'd4);
      add_row(CMD_READ,   64'd0, 12'd30, 6'd0);
      add_row(CMD_ADD,    64'h7FFF_FFFF_FFFF_F01F, 12'd0, 6'd0);
      add_row(CMD_ADD,    64'h8000_0000_0000_0FFF, 12'hFFF, 6'h2A);
      add_row(CMD_READ,   64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, 6'h15);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PAUSE_AT) begin
            send_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            hot_base   = $urandom_range(0, REG_COUNT - 1);
            gap        = (i >= 300 && i < 500) ? 0 : $urandom_range(0, 6);
            if (gap > 0 && i != PAUSE_AT) begin
               send_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         item = random_item();
         send_item(item, 1'b0, no_result);
      end
      send_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("testbench: %0d adds, %0d merges, %0d reads, %0d unused-code reads sent",
               cmd_seen[CMD_ADD], cmd_seen[CMD_MERGE], cmd_seen[CMD_READ],
               cmd_seen[CMD_UNUSED]);
      $display("testbench: %0d results checked, %0d registers left at zero, %0d mismatches",
               results_checked, sketch_zeros, error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
